// File: rtl/qrm_pkg.sv
package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int N_ENT     = 9;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS + 1;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int RES_W     = FRAC_BITS + 2;
    localparam int WIDE_W    = 32;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(32767);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(32768);

    typedef logic signed [IN_W-1:0]   t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic [DVD_W-1:0]         t_dvd;
    typedef logic [QUO_W-1:0]         t_quo;
    typedef logic [OUT_W-1:0]         t_ent;

    typedef struct packed {
        logic             zero;
        logic [N_ENT-1:0] neg;
    } t_ctrl;

    typedef struct packed {
        t_ctrl                ctrl;
        t_mag                 den;
        t_dvd [N_ENT-1:0]     rem;
        t_quo [N_ENT-1:0]     quo;
    } t_div;

    // sign, then clamp to the 16-bit field
    function automatic t_ent sat_entry(t_quo q, logic neg);
        logic signed [RES_W-1:0]  v;
        logic signed [WIDE_W-1:0] wv;
        t_ent                     res;
        v  = signed'({1'b0, q});
        if (neg) begin
            v = -v;
        end
        wv = WIDE_W'(v);
        if (wv > SAT_MAX) begin
            res = t_ent'(SAT_MAX);
        end else if (wv < SAT_MIN) begin
            res = t_ent'(SAT_MIN);
        end else begin
            res = wv[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/qrm_front.sv
module qrm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [4*qrm_pkg::IN_W-1:0] i_data,
    output logic                       o_valid,
    output qrm_pkg::t_div              o_div
);

    qrm_pkg::t_comp x, y, z, w;

    // stage 1: products
    logic           r_v1;
    qrm_pkg::t_prod r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_xw, r_yw, r_zw;
    qrm_pkg::t_prod n_xx, n_yy, n_zz, n_ww, n_xy, n_xz, n_yz, n_xw, n_yw, n_zw;

    // stage 2: norm and numerators
    logic           r_v2;
    qrm_pkg::t_sum  r_nrm;
    qrm_pkg::t_sum  r_num [qrm_pkg::N_ENT];
    qrm_pkg::t_sum  n_nrm;
    qrm_pkg::t_sum  n_num [qrm_pkg::N_ENT];

    // stage 3: magnitude, sign, rounded dividend
    logic           r_v3;
    qrm_pkg::t_div  r_div;
    qrm_pkg::t_div  n_div;

    assign x = signed'(i_data[1*qrm_pkg::IN_W-1:0*qrm_pkg::IN_W]);
    assign y = signed'(i_data[2*qrm_pkg::IN_W-1:1*qrm_pkg::IN_W]);
    assign z = signed'(i_data[3*qrm_pkg::IN_W-1:2*qrm_pkg::IN_W]);
    assign w = signed'(i_data[4*qrm_pkg::IN_W-1:3*qrm_pkg::IN_W]);

    always_comb begin
        n_xx = x * x;
        n_yy = y * y;
        n_zz = z * z;
        n_ww = w * w;
        n_xy = x * y;
        n_xz = x * z;
        n_yz = y * z;
        n_xw = x * w;
        n_yw = y * w;
        n_zw = z * w;
    end

    always_comb begin
        qrm_pkg::t_sum xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
        xx = qrm_pkg::SUM_W'(r_xx);
        yy = qrm_pkg::SUM_W'(r_yy);
        zz = qrm_pkg::SUM_W'(r_zz);
        ww = qrm_pkg::SUM_W'(r_ww);
        xy = qrm_pkg::SUM_W'(r_xy);
        xz = qrm_pkg::SUM_W'(r_xz);
        yz = qrm_pkg::SUM_W'(r_yz);
        xw = qrm_pkg::SUM_W'(r_xw);
        yw = qrm_pkg::SUM_W'(r_yw);
        zw = qrm_pkg::SUM_W'(r_zw);
        n_nrm    = xx + yy + zz + ww;
        n_num[0] = n_nrm - ((yy + zz) <<< 1);
        n_num[1] = (xy - zw) <<< 1;
        n_num[2] = (xz + yw) <<< 1;
        n_num[3] = (xy + zw) <<< 1;
        n_num[4] = n_nrm - ((xx + zz) <<< 1);
        n_num[5] = (yz - xw) <<< 1;
        n_num[6] = (xz - yw) <<< 1;
        n_num[7] = (yz + xw) <<< 1;
        n_num[8] = n_nrm - ((xx + yy) <<< 1);
    end

    always_comb begin
        qrm_pkg::t_mag den;
        qrm_pkg::t_sum am;
        den = r_nrm[qrm_pkg::MAG_W-1:0];
        n_div.ctrl.zero = (den == '0);
        n_div.den       = den;
        for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
            n_div.ctrl.neg[i] = r_num[i][qrm_pkg::SUM_W-1];
            am = n_div.ctrl.neg[i] ? -r_num[i] : r_num[i];
            n_div.rem[i] = (qrm_pkg::DVD_W'(am[qrm_pkg::MAG_W-1:0]) << qrm_pkg::FRAC_BITS)
                         + qrm_pkg::DVD_W'(den >> 1);
            n_div.quo[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx  <= n_xx;
            r_yy  <= n_yy;
            r_zz  <= n_zz;
            r_ww  <= n_ww;
            r_xy  <= n_xy;
            r_xz  <= n_xz;
            r_yz  <= n_yz;
            r_xw  <= n_xw;
            r_yw  <= n_yw;
            r_zw  <= n_zw;
            r_nrm <= n_nrm;
            r_num <= n_num;
            r_div <= n_div;
        end
    end

    assign o_valid = r_v3;
    assign o_div   = r_div;

endmodule

// File: rtl/qrm_divider.sv
module qrm_divider (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qrm_pkg::t_div i_div,
    output logic          o_valid,
    output qrm_pkg::t_div o_div
);

    // restoring division, one quotient bit per stage, MSB first
    qrm_pkg::t_div          w_stg [qrm_pkg::QUO_W+1];
    logic [qrm_pkg::QUO_W:0] w_vld;

    assign w_stg[0] = i_div;
    assign w_vld[0] = i_valid;

    for (genvar k = 0; k < qrm_pkg::QUO_W; k++) begin : g_stage
        localparam int SH = qrm_pkg::QUO_W - 1 - k;
        qrm_pkg::t_div n_div;
        qrm_pkg::t_div r_div;
        logic          r_vld;

        always_comb begin
            qrm_pkg::t_dvd dsh;
            logic          ge;
            dsh   = qrm_pkg::DVD_W'(w_stg[k].den) << SH;
            n_div = w_stg[k];
            for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
                ge = (w_stg[k].rem[i] >= dsh);
                n_div.rem[i] = ge ? (w_stg[k].rem[i] - dsh) : w_stg[k].rem[i];
                n_div.quo[i] = {w_stg[k].quo[i][qrm_pkg::QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div <= n_div;
            end
        end

        assign w_stg[k+1] = r_div;
        assign w_vld[k+1] = r_vld;
    end

    assign o_valid = w_vld[qrm_pkg::QUO_W];
    assign o_div   = w_stg[qrm_pkg::QUO_W];

endmodule

// File: rtl/qrm_output.sv
module qrm_output (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  qrm_pkg::t_div                       i_div,
    output logic                                o_valid,
    output logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0] o_data,
    output logic                                o_zero
);

    logic                                       r_valid;
    logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0]   r_data;
    logic                                       r_zero;
    logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0]   n_data;

    always_comb begin
        qrm_pkg::t_quo one;
        logic          diag;
        one = qrm_pkg::QUO_W'(1) << qrm_pkg::FRAC_BITS;
        for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
            diag = (i == 0) || (i == 4) || (i == 8);
            if (i_div.ctrl.zero) begin
                n_data[i*qrm_pkg::OUT_W +: qrm_pkg::OUT_W] =
                    diag ? qrm_pkg::sat_entry(one, 1'b0) : '0;
            end else begin
                n_data[i*qrm_pkg::OUT_W +: qrm_pkg::OUT_W] =
                    qrm_pkg::sat_entry(i_div.quo[i], i_div.ctrl.neg[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_zero <= i_div.ctrl.zero;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_zero  = r_zero;

endmodule

// File: rtl/quaternion_to_rotation_matrix_unit.sv
// Quaternion to 3x3 rotation matrix, streaming.
// Slave side: one quaternion per transfer, x y z w as signed Q2.14 in tdata.
// Master side: the nine entries r00..r22 of the rotation matrix of the
// normalised quaternion, signed Q2.14, rounded to nearest; tuser flags an
// all-zero quaternion, for which the identity matrix is returned.
// Pipeline: o_m_tvalid follows the input transfer through 19 register
// stages (3 front stages for products, sums and dividend, 15 restoring
// divider stages at one quotient bit each, 1 output register).
// Throughput: one quaternion per cycle while the receiver keeps up.
// Reset (i_rst_n low, synchronous) empties the pipeline; no item is
// delivered until new transfers arrive.
// Receiver stall: while a result waits on the output with i_m_tready low the
// whole pipeline holds and o_s_tready is low; nothing is lost or repeated.
module quaternion_to_rotation_matrix_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    input  logic [4*qrm_pkg::IN_W-1:0]               i_s_tdata,  // quat_x, quat_y, quat_z, quat_w
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    output logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0] o_m_tdata,  // r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic                                     o_m_tuser   // zero_input
);

    logic          w_en;
    logic          w_fr_valid;
    qrm_pkg::t_div w_fr_div;
    logic          w_dv_valid;
    qrm_pkg::t_div w_dv_div;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (w_fr_valid),
        .o_div   (w_fr_div)
    );

    qrm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_div   (w_fr_div),
        .o_valid (w_dv_valid),
        .o_div   (w_dv_div)
    );

    qrm_output u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_valid),
        .i_div   (w_dv_div),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_zero  (o_m_tuser)
    );

endmodule

// File: dv/tb_quaternion_to_rotation_matrix_unit.sv
module tb_quaternion_to_rotation_matrix_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [4*qrm_pkg::IN_W-1:0]                     quat;
        logic                                           zero;
        logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0]  ent;
    } t_rot_matrix;

    class t_rot_scoreboard;
        t_rot_matrix matrices_due[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return matrices_due.size();
        endfunction

        // round(num * 2^FRAC_BITS / den), ties away from zero, den > 0
        function longint round_ratio(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = ((mag << qrm_pkg::FRAC_BITS) + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function logic [qrm_pkg::OUT_W-1:0] clamp_entry(longint v);
            if (v > 32767) begin
                v = 32767;
            end else if (v < -32768) begin
                v = -32768;
            end
            return v[qrm_pkg::OUT_W-1:0];
        endfunction

        function t_rot_matrix rotate_of(logic [4*qrm_pkg::IN_W-1:0] q);
            t_rot_matrix m;
            longint      x, y, z, w, n;
            longint      xx, yy, zz, xy, xz, yz, xw, yw, zw;
            longint      v [qrm_pkg::N_ENT];
            x  = longint'($signed(q[0*qrm_pkg::IN_W +: qrm_pkg::IN_W]));
            y  = longint'($signed(q[1*qrm_pkg::IN_W +: qrm_pkg::IN_W]));
            z  = longint'($signed(q[2*qrm_pkg::IN_W +: qrm_pkg::IN_W]));
            w  = longint'($signed(q[3*qrm_pkg::IN_W +: qrm_pkg::IN_W]));
            xx = x * x;
            yy = y * y;
            zz = z * z;
            xy = x * y;
            xz = x * z;
            yz = y * z;
            xw = x * w;
            yw = y * w;
            zw = z * w;
            n  = xx + yy + zz + w * w;
            m.quat = q;
            if (n == 0) begin
                m.zero = 1'b1;
                for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
                    v[i] = (i % 4 == 0) ? (longint'(1) << qrm_pkg::FRAC_BITS) : 0;
                end
            end else begin
                m.zero = 1'b0;
                v[0] = round_ratio(n - 2 * (yy + zz), n);
                v[1] = round_ratio(2 * (xy - zw), n);
                v[2] = round_ratio(2 * (xz + yw), n);
                v[3] = round_ratio(2 * (xy + zw), n);
                v[4] = round_ratio(n - 2 * (xx + zz), n);
                v[5] = round_ratio(2 * (yz - xw), n);
                v[6] = round_ratio(2 * (xz - yw), n);
                v[7] = round_ratio(2 * (yz + xw), n);
                v[8] = round_ratio(n - 2 * (xx + yy), n);
            end
            for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
                m.ent[i] = clamp_entry(v[i]);
            end
            return m;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) begin
                $display("%0t ERROR: %s", $realtime, msg);
            end
            errors++;
        endtask

        task note_quat(logic [4*qrm_pkg::IN_W-1:0] q);
            matrices_due.push_back(rotate_of(q));
        endtask

        task check_matrix(logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0] d, logic zflag);
            t_rot_matrix               m;
            logic [qrm_pkg::OUT_W-1:0] got;
            if (matrices_due.size() == 0) begin
                report("result transfer with no quaternion outstanding");
            end else begin
                m = matrices_due.pop_front();
                for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
                    got = d[i*qrm_pkg::OUT_W +: qrm_pkg::OUT_W];
                    if (got !== m.ent[i]) begin
                        report($sformatf("r%0d%0d exp %0d got %0d, quat %h",
                            i / 3, i % 3, $signed(m.ent[i]), $signed(got), m.quat));
                    end
                end
                if (zflag !== m.zero) begin
                    report($sformatf("zero flag exp %0b got %0b, quat %h",
                        m.zero, zflag, m.quat));
                end
            end
        endtask
    endclass

    logic                                     i_clk;
    logic                                     i_rst_n;
    logic                                     i_s_tvalid;
    logic                                     o_s_tready;
    logic [4*qrm_pkg::IN_W-1:0]               i_s_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic                                     o_m_tvalid;
    logic                                     i_m_tready;
    logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0] o_m_tdata;   // r00 r01 r02 r10 r11 r12 r20 r21 r22
    logic                                     o_m_tuser;   // zero_input

    t_rot_scoreboard sb = new();
    bit              hold_req = 1'b0;
    int              idle_cycles = 0;

    quaternion_to_rotation_matrix_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // transfer monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_quat(i_s_tdata);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_matrix(o_m_tdata, o_m_tuser);
        end
        if (i_rst_n && ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("quaternion_to_rotation_matrix_unit test failed");
            $finish;
        end
    end

    // receiver back-pressure
    initial begin
        int mode;
        int len;
        int cnt;
        bit rdy;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        cnt = 0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 80);
            repeat (len) begin
                if (hold_req) begin
                    i_m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: rdy = 1'b1;
                        1: rdy = 1'($urandom_range(0, 1));
                        2: rdy = ($urandom_range(0, 3) == 0);
                        default: rdy = (cnt % 8) < 5;
                    endcase
                    cnt++;
                    i_m_tready <= rdy;
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic logic [qrm_pkg::IN_W-1:0] rand_comp(int lo, int hi);
        int v;
        v = $urandom_range(0, hi - lo) + lo;
        return v[qrm_pkg::IN_W-1:0];
    endfunction

    function automatic logic [4*qrm_pkg::IN_W-1:0] rand_quat();
        logic [4*qrm_pkg::IN_W-1:0] q;
        int kind;
        int big;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            q = {$urandom(), $urandom()};
        end else if (kind < 70) begin
            for (int i = 0; i < 4; i++) begin
                q[i*qrm_pkg::IN_W +: qrm_pkg::IN_W] = rand_comp(-16384, 16384);
            end
        end else if (kind < 85) begin
            for (int i = 0; i < 4; i++) begin
                q[i*qrm_pkg::IN_W +: qrm_pkg::IN_W] = rand_comp(-4, 4);
            end
        end else begin
            big = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) begin
                q[i*qrm_pkg::IN_W +: qrm_pkg::IN_W] = (i == big) ? rand_comp(-32768, 32767)
                                                                 : rand_comp(-64, 64);
            end
        end
        return q;
    endfunction

    function automatic logic [4*qrm_pkg::IN_W-1:0] quat_of(int x, int y, int z, int w);
        logic [qrm_pkg::IN_W-1:0] xs, ys, zs, ws;
        xs = x[qrm_pkg::IN_W-1:0];
        ys = y[qrm_pkg::IN_W-1:0];
        zs = z[qrm_pkg::IN_W-1:0];
        ws = w[qrm_pkg::IN_W-1:0];
        return {ws, zs, ys, xs};
    endfunction

    task automatic offer_quat(input logic [4*qrm_pkg::IN_W-1:0] q);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= q;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic stream_quats(input logic [4*qrm_pkg::IN_W-1:0] items[$]);
        int burst;
        int gap;
        burst = 0;
        foreach (items[i]) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 40);
            end
            offer_quat(items[i]);
            burst--;
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_matrices();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [4*qrm_pkg::IN_W-1:0] directed[$];
        logic [4*qrm_pkg::IN_W-1:0] rnd[$];
        logic [4*qrm_pkg::IN_W-1:0] part[$];
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{
            quat_of(0, 0, 0, 0),
            quat_of(0, 0, 0, 16384),
            quat_of(16384, 0, 0, 0),
            quat_of(0, 16384, 0, 0),
            quat_of(0, 0, 16384, 0),
            quat_of(0, 0, 0, -16384),
            quat_of(-32768, -32768, -32768, -32768),
            quat_of(32767, 32767, 32767, 32767),
            quat_of(32767, -32768, 32767, -32768),
            quat_of(-32768, 0, 0, 0),
            quat_of(0, 0, 0, 32767),
            quat_of(1, 0, 0, 0),
            quat_of(0, 0, 0, -1),
            quat_of(1, 1, 1, 1),
            quat_of(1, 1, 0, 0),
            quat_of(1, 1, 1, 0),
            quat_of(3, 4, 0, 0),
            quat_of(8192, 8192, 8192, 8192),
            quat_of(11585, 0, 0, 11585),
            quat_of(-32768, 0, 0, 1),
            quat_of(100, -200, 300, -400),
            quat_of(-1, 2, -3, 5),
            quat_of(0, 0, 0, 0)
        };
        stream_quats(directed);
        drain_matrices();

        repeat (1230) rnd.push_back(rand_quat());

        part = rnd[0:299];
        stream_quats(part);
        // receiver holds off while the sender keeps offering
        hold_req = 1'b1;
        part = rnd[300:699];
        stream_quats(part);
        drain_matrices();
        part = rnd[700:$];
        stream_quats(part);

        drain_matrices();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("quaternion_to_rotation_matrix_unit test passed");
        end else begin
            $display("quaternion_to_rotation_matrix_unit test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/qrm_pkg.sv
rtl/qrm_front.sv
rtl/qrm_divider.sv
rtl/qrm_output.sv
rtl/quaternion_to_rotation_matrix_unit.sv
dv/tb_quaternion_to_rotation_matrix_unit.sv
